// File: rtl/bounded_deque_sorted_list_unit_assert.svh
// Assertion macros shared by the deque unit's RTL.
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef BOUNDED_DEQUE_SORTED_LIST_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_SORTED_LIST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BDSL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdsl assertion failed");
// next-cycle implication, checked out of reset
`define BDSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdsl assertion failed");
`else
`define BDSL_ASSERT_SAME(lbl, ante, cons)
`define BDSL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/bdsl_pkg.sv
// Shared types and codes for the bounded deque / sorted list unit.
// No dependencies.
`default_nettype none
package bdsl_pkg;

  // operation codes; the eighth code is a no-op
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DELETE     = 3'd4,
    KIND_SEARCH     = 3'd5,
    KIND_INSERT     = 3'd6
  } kind_t;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture; // take operand and register compare vectors
    logic commit;  // apply the operation and load the result register
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/bdsl_ctrl.sv
// Controller for the deque unit: sequences capture and commit, owns out_valid.
// Depends on bdsl_pkg and the assertion header.
`default_nettype none
`include "bounded_deque_sorted_list_unit_assert.svh"
module bdsl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output bdsl_pkg::cmd_t  cmd
);
  import bdsl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new beat
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid: set on commit, held while stalled
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BDSL_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall)
  `BDSL_ASSERT_SAME(a_commit_free, cmd.commit, !(out_valid && out_stall))
  `BDSL_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid)

endmodule
`default_nettype wire

// File: rtl/bdsl_dp.sv
// Datapath for the deque unit: entry registers, compare vectors, shift update
// and result register. Depends on bdsl_pkg and the assertion header.
`default_nettype none
`include "bounded_deque_sorted_list_unit_assert.svh"
module bdsl_dp #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bdsl_pkg::cmd_t     cmd,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_operand_value,
  output logic signed [31:0] out_popped_value,
  output logic               out_found,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count
);
  import bdsl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] entries_r [CAPACITY];
  logic signed [31:0] entries_nxt [CAPACITY];
  logic signed [31:0] ins_word [CAPACITY];
  logic signed [31:0] rem_word [CAPACITY];
  logic [CW-1:0]      count_r, count_nxt;
  kind_t              kind_r;
  logic signed [31:0] val_r;
  logic [CAPACITY-1:0] eq_r, eq_nxt, ge_r, ge_nxt;

  logic [CAPACITY-1:0] valid_m, end_oh, last_oh, eq_hit, ge_hit, eq_first, ge_first;
  logic [CAPACITY-1:0] pos, keep_m;
  logic               full, empty, do_ins, do_rem;
  logic signed [31:0] popped, sel_word;
  logic               found;
  logic [1:0]         status;

  // parallel compare of the incoming operand against every entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      eq_nxt[i] = (entries_r[i] == in_operand_value);
      ge_nxt[i] = (entries_r[i] >= in_operand_value);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind_t'(in_kind);
      val_r  <= in_operand_value;
      eq_r   <= eq_nxt;
      ge_r   <= ge_nxt;
    end
  end

  // occupancy masks
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_m[i] = (CW'(i) < count_r);
      end_oh[i]  = (CW'(i) == count_r);
      last_oh[i] = (CW'(i + 1) == count_r);
    end
  end

  // first hit from the front: isolate lowest set bit
  assign eq_hit   = eq_r & valid_m;
  assign ge_hit   = ge_r & valid_m;
  assign eq_first = eq_hit & (~eq_hit + CAPACITY'(1));
  assign ge_first = ge_hit & (~ge_hit + CAPACITY'(1));
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);

  // operation decode
  always_comb begin
    pos    = '0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    found  = 1'b0;
    status = STATUS_OK;
    unique case (kind_r)
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          do_ins = 1'b1;
          if (kind_r == KIND_PUSH_FRONT) pos = CAPACITY'(1);
          else if (kind_r == KIND_PUSH_BACK) pos = end_oh;
          else pos = (|ge_hit) ? ge_first : end_oh;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          do_rem = 1'b1;
          pos    = (kind_r == KIND_POP_FRONT) ? CAPACITY'(1) : last_oh;
        end
      end
      KIND_DELETE: begin
        found  = |eq_hit;
        do_rem = |eq_hit;
        pos    = eq_first;
      end
      KIND_SEARCH: begin
        found = |eq_hit;
      end
      default: begin
        status = STATUS_OK;
      end
    endcase
  end

  // positions in front of the gap keep their word
  assign keep_m = pos - CAPACITY'(1);

  // word at the chosen position
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++)
      sel_word = sel_word | (pos[i] ? entries_r[i] : 32'sd0);
  end

  assign popped = (do_rem && (kind_r == KIND_POP_FRONT || kind_r == KIND_POP_BACK))
                  ? sel_word : 32'sd0;

  // shifted words for insert and remove
  for (genvar g = 0; g < CAPACITY; g++) begin : g_shift
    if (g == 0) begin : g_first
      assign ins_word[g] = keep_m[g] ? entries_r[g] : (pos[g] ? val_r : entries_r[g]);
    end else begin : g_rest
      assign ins_word[g] = keep_m[g] ? entries_r[g] : (pos[g] ? val_r : entries_r[g-1]);
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rem_word[g] = entries_r[g];
    end else begin : g_body
      assign rem_word[g] = keep_m[g] ? entries_r[g] : entries_r[g+1];
    end
  end

  // next entries and count
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = entries_r[i];
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
      for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = ins_word[i];
    end else if (do_rem) begin
      count_nxt = count_r - CW'(1);
      for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = rem_word[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < CAPACITY; i++) entries_r[i] <= entries_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_popped_value <= popped;
      out_found        <= found;
      out_status       <= status;
      out_entry_count  <= 5'(count_nxt);
    end
  end

  `BDSL_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  `BDSL_ASSERT_NEXT(a_count_hold, !cmd.commit, $stable(count_r))
  `BDSL_ASSERT_SAME(a_pos_onehot, cmd.commit && (do_ins || do_rem), $onehot(pos))

endmodule
`default_nettype wire

// File: rtl/bounded_deque_sorted_list_unit.sv
// Top level of the bounded deque / sorted list unit.
// Depends on bdsl_pkg, bdsl_ctrl and bdsl_dp.
//
// Holds an ordered list of up to CAPACITY signed 32-bit words and runs one
// operation per input beat (push front/back, pop front/back, delete first
// match, search, sorted insert), returning one result beat each. In the accept
// cycle the operand is compared against every entry in parallel and the
// compare vectors are registered; in the execute state the first hit is picked,
// the entry registers shift and the result register loads. The next beat is
// taken in the cycle after that result loads, so a new operation is not taken
// before the last one has committed; a stalled result holds the commit cycle.
// Entry contents are undefined after reset, only the count clears, so no
// clearing pass is needed. entry_count is the count taken modulo 32.
`default_nettype none
module bounded_deque_sorted_list_unit #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_popped_value,
  output logic               out_found,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count
);
  import bdsl_pkg::*;

  cmd_t cmd;

  // sequencing
  bdsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // storage and operation logic
  bdsl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_operand_value (in_operand_value),
    .out_popped_value (out_popped_value),
    .out_found        (out_found),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

endmodule
`default_nettype wire

// File: test/tb_bounded_deque_sorted_list_unit.sv
// Self-checking testbench for bounded_deque_sorted_list_unit: a directed table, then random
// fill and drain phases, checked beat by beat against a queue-based model of the list.
// Depends on bdsl_pkg and the unit's RTL only.
module tb_bounded_deque_sorted_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bdsl_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int RANDOM_ITEMS  = 600;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PRINT_LIMIT   = 40;

  // the eighth operation code has no package name; the unit treats it as a no-op
  localparam logic [2:0] KIND_NOP = 3'd7;

  localparam logic signed [31:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_WORD = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CORNER_VALUES [4] = '{MIN_WORD, MAX_WORD, 32'sd0, -32'sd1};

  typedef struct packed {
    logic signed [31:0] popped;
    logic               found;
    logic [1:0]         status;
    logic [4:0]         count;
  } op_result_t;

  // one directed row: repeated rep times with the operand stepped by one each time
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [4:0]         rep;
    logic               literal_ok;
    op_result_t         result;
  } op_row_t;

  localparam op_result_t NO_LITERAL = '0;

  localparam int DIRECTED_ROWS = 25;
  localparam op_row_t DIRECTED_OPS [DIRECTED_ROWS] = '{
    // empty list: pops report empty, look-ups miss, the spare code changes nothing
    '{KIND_POP_FRONT,  32'sd0,   5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_EMPTY, 5'd0}},
    '{KIND_POP_BACK,   -32'sd1,  5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_EMPTY, 5'd0}},
    '{KIND_SEARCH,     32'sd0,   5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_OK, 5'd0}},
    '{KIND_DELETE,     32'sd0,   5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_OK, 5'd0}},
    '{KIND_NOP,   32'sh5A5A_5A5A, 5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_OK, 5'd0}},
    // extremes at both ends, then sorted inserts between them
    '{KIND_PUSH_BACK,  MAX_WORD, 5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_OK, 5'd1}},
    '{KIND_PUSH_FRONT, MIN_WORD, 5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_OK, 5'd2}},
    '{KIND_INSERT,     32'sd0,   5'd1, 1'b0, NO_LITERAL},
    '{KIND_INSERT,     -32'sd1,  5'd1, 1'b0, NO_LITERAL},
    '{KIND_INSERT,     MAX_WORD, 5'd1, 1'b0, NO_LITERAL},  // tie lands ahead of its equal
    '{KIND_SEARCH,     -32'sd1,  5'd1, 1'b0, NO_LITERAL},
    '{KIND_POP_BACK,   32'sd0,   5'd1, 1'b1, '{MAX_WORD, 1'b0, STATUS_OK, 5'd4}},
    '{KIND_POP_FRONT,  32'sd0,   5'd1, 1'b1, '{MIN_WORD, 1'b0, STATUS_OK, 5'd3}},
    '{KIND_DELETE,     32'sd0,   5'd1, 1'b0, NO_LITERAL},
    '{KIND_DELETE,     32'sd0,   5'd1, 1'b0, NO_LITERAL},  // now absent
    // fill to capacity, then every growing operation is refused
    '{KIND_PUSH_BACK,  32'sd10,  5'd14, 1'b0, NO_LITERAL},
    '{KIND_PUSH_FRONT, 32'sd1,   5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_FULL, 5'd16}},
    '{KIND_PUSH_BACK,  32'sd1,   5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_FULL, 5'd16}},
    '{KIND_INSERT,     32'sd1,   5'd1, 1'b1, '{32'sd0, 1'b0, STATUS_FULL, 5'd16}},
    '{KIND_SEARCH,     32'sd23,  5'd1, 1'b0, NO_LITERAL},
    '{KIND_POP_BACK,   32'sd0,   5'd16, 1'b0, NO_LITERAL},
    // sorted insert into an unsorted list
    '{KIND_PUSH_BACK,  32'sd10,  5'd1, 1'b0, NO_LITERAL},
    '{KIND_PUSH_BACK,  32'sd2,   5'd1, 1'b0, NO_LITERAL},
    '{KIND_INSERT,     32'sd5,   5'd1, 1'b0, NO_LITERAL},
    '{KIND_INSERT,     32'sd15,  5'd1, 1'b0, NO_LITERAL}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_kind;
  logic signed [31:0] in_operand_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_popped_value;
  logic               out_found;
  logic [1:0]         out_status;
  logic [4:0]         out_entry_count;

  // travels with each beat: a literal result that replaces the model's
  logic               beat_has_literal;
  op_result_t         beat_literal;

  logic signed [31:0] held_values [$];
  op_result_t         pending_results [$];
  int                 error_count;
  int                 burst_left;

  bounded_deque_sorted_list_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_operand_value(in_operand_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_popped_value(out_popped_value),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // list model: applies one operation and returns the result beat it causes
  function automatic op_result_t apply_list_op(input logic [2:0] kind,
                                               input logic signed [31:0] value);
    op_result_t res;
    int         pos;
    res = '0;
    res.status = STATUS_OK;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            pos = 0;
          end else if (kind == KIND_PUSH_BACK) begin
            pos = held_values.size();
          end else begin
            pos = 0;
            while (pos < held_values.size() && held_values[pos] < value) pos++;
          end
          held_values.insert(pos, value);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (held_values.size() == 0) res.status = STATUS_EMPTY;
        else if (kind == KIND_POP_FRONT) res.popped = held_values.pop_front();
        else res.popped = held_values.pop_back();
      end
      KIND_DELETE, KIND_SEARCH: begin
        pos = 0;
        while (pos < held_values.size() && held_values[pos] !== value) pos++;
        if (pos < held_values.size()) begin
          res.found = 1'b1;
          if (kind == KIND_DELETE) held_values.delete(pos);
        end
      end
      default: ;
    endcase
    res.count = 5'(held_values.size());
    return res;
  endfunction

  // every accepted input beat: run the model, queue what should come back
  always @(posedge clk) begin : predict_on_accept
    op_result_t outcome;
    if (rst_n && in_valid && !in_stall) begin
      outcome = apply_list_op(in_kind, in_operand_value);
      pending_results.push_back(beat_has_literal ? beat_literal : outcome);
    end
  end

  // every accepted result beat against the oldest expectation
  always @(posedge clk) begin : check_results
    op_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_popped_value !== want.popped)
          report_mismatch($sformatf("popped_value %h, want %h", out_popped_value, want.popped));
        if (out_found !== want.found)
          report_mismatch($sformatf("found %b, want %b", out_found, want.found));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("entry_count %0d, want %0d", out_entry_count, want.count));
      end
    end
  end

  // result side stalls in stretches of changing density, some with none at all
  initial begin : result_backpressure
    int mode;
    int span;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // drives one beat, holds it until taken, then maybe opens a gap before the next
  task automatic send_op(input logic [2:0] kind, input logic signed [31:0] value,
                         input logic has_literal, input op_result_t literal);
    int gap;
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_operand_value <= value;
    beat_has_literal <= has_literal;
    beat_literal     <= literal;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // operand choice: held entries for hits, small values for ties, corners, full range
  function automatic logic signed [31:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && held_values.size() > 0)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    if (sel < 7) return $signed(32'($urandom_range(0, 7))) - 32'sd4;
    if (sel == 7) return CORNER_VALUES[$urandom_range(0, 3)];
    return $signed($urandom);
  endfunction

  initial begin : stimulus
    int         row;
    int         step;
    int         n;
    int         roll;
    bit         filling;
    logic [2:0] kind;
    error_count = 0;
    burst_left  = 1;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_NOP;
    in_operand_value <= '0;
    beat_has_literal <= 1'b0;
    beat_literal     <= NO_LITERAL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (row = 0; row < DIRECTED_ROWS; row++)
      for (step = 0; step < DIRECTED_OPS[row].rep; step++)
        send_op(DIRECTED_OPS[row].kind, DIRECTED_OPS[row].value + step,
                DIRECTED_OPS[row].literal_ok && DIRECTED_OPS[row].rep == 1,
                DIRECTED_OPS[row].result);

    // random phases that lean towards filling or draining the list
    filling = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) filling = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (filling) begin
        if (roll < 20) kind = KIND_PUSH_FRONT;
        else if (roll < 40) kind = KIND_PUSH_BACK;
        else if (roll < 62) kind = KIND_INSERT;
        else if (roll < 70) kind = KIND_POP_FRONT;
        else if (roll < 78) kind = KIND_POP_BACK;
        else if (roll < 86) kind = KIND_DELETE;
        else if (roll < 96) kind = KIND_SEARCH;
        else kind = KIND_NOP;
      end else begin
        if (roll < 8) kind = KIND_PUSH_FRONT;
        else if (roll < 16) kind = KIND_PUSH_BACK;
        else if (roll < 26) kind = KIND_INSERT;
        else if (roll < 48) kind = KIND_POP_FRONT;
        else if (roll < 70) kind = KIND_POP_BACK;
        else if (roll < 85) kind = KIND_DELETE;
        else if (roll < 96) kind = KIND_SEARCH;
        else kind = KIND_NOP;
      end
      send_op(kind, pick_operand(), 1'b0, NO_LITERAL);
    end

    // let everything outstanding come back, then idle before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: bounded_deque_sorted_list_unit.f
+incdir+rtl
rtl/bdsl_pkg.sv
rtl/bdsl_ctrl.sv
rtl/bdsl_dp.sv
rtl/bounded_deque_sorted_list_unit.sv
test/tb_bounded_deque_sorted_list_unit.sv
